[hw/rtl/vpd_pkg.sv]
// Shared constants and result type for the video packet deframer.
// No dependencies.
package vpd_pkg;

  localparam int PACKET_BYTES     = 164;
  localparam int PACKETS_IN_FRAME = 60;
  localparam int HEADER_WORDS     = 2;
  localparam int HEADER_BYTES     = 2 * HEADER_WORDS;
  localparam int LAST_PIXEL_POS   =
    HEADER_BYTES + 2 * ((PACKET_BYTES - HEADER_BYTES) / 2) - 1;

  localparam int POS_W    = 8;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 7;
  localparam int PIXEL_W  = 16;
  localparam int COUNT_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;

  // Byte positions inside a packet
  localparam logic [POS_W-1:0] ID_POS       = POS_W'(1);
  localparam logic [POS_W-1:0] HDR_END_POS  = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] PKT_LAST_POS = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] LAST_PIX_POS = POS_W'(LAST_PIXEL_POS);
  localparam logic [ROW_W-1:0] LAST_INDEX   = ROW_W'(PACKETS_IN_FRAME - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  // Result kinds
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [PIXEL_W-1:0] pixel;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    logic               frame_end;
    logic [COUNT_W-1:0] resync_count;
  } res_t;

endpackage

[hw/rtl/video_packet_deframer.sv]
// Video packet deframer: byte stream in, pixel / reject results out.
// Depends on vpd_pkg.
//
// channel | dir | tdata (low bit up)                          | tuser | tlast
// s_*     | in  | in_byte[7:0]                                | -     | -
// m_*     | out | pixel[15:0] row[21:16] column[28:22]        | kind  | frame_end
//         |     | resync_count[44:29], zero [47:45]           |       |
//
// One byte is taken per cycle while s_tready is high; its result, if any, is
// registered in the output register, or in the skid register while the sink stalls.
// s_tready is registered and drops only while both hold results not yet taken.
// rst is synchronous, active high: packet position, frame index, resync count
// and both output stages clear.
module video_packet_deframer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [vpd_pkg::IN_DATA_W-1:0]  s_tdata,   // in_byte[7:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [vpd_pkg::OUT_DATA_W-1:0] m_tdata,   // pixel, row, column, resync_count
  output logic                           m_tuser,   // kind
  output logic                           m_tlast    // frame_end
);
  import vpd_pkg::*;

  logic [POS_W-1:0]   pos, pos_next;
  logic [ROW_W-1:0]   expected_index, expected_index_next;
  logic               packet_accepted, packet_accepted_next;
  logic [BYTE_W-1:0]  high_byte_hold, high_byte_hold_next;
  logic [COUNT_W-1:0] resync_total, resync_total_next;

  logic               res_valid;
  res_t               res;
  logic [POS_W-1:0]   off;
  logic [BYTE_W-1:0]  in_byte;
  logic               accept;

  logic               out_valid, skid_valid;
  res_t               out_res, skid_res;

  assign in_byte  = s_tdata[BYTE_W-1:0];
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign off      = pos - HDR_END_POS;

  always_comb begin
    pos_next             = pos + POS_W'(1);
    expected_index_next  = expected_index;
    packet_accepted_next = packet_accepted;
    high_byte_hold_next  = high_byte_hold;
    resync_total_next    = resync_total;
    res_valid            = 1'b0;
    res                  = '0;

    if (pos == ID_POS) begin
      if (in_byte == {{(BYTE_W-ROW_W){1'b0}}, expected_index}) begin
        packet_accepted_next = 1'b1;
      end else begin
        packet_accepted_next = 1'b0;
        if (resync_total != COUNT_MAX) begin
          resync_total_next = resync_total + COUNT_W'(1);
        end
        res_valid            = 1'b1;
        res.kind             = KIND_REJECT;
        res.row              = expected_index;
        res.resync_count     = resync_total_next;
        expected_index_next  = '0;
      end
    end else if (pos >= HDR_END_POS && packet_accepted) begin
      if (!off[0]) begin
        high_byte_hold_next = in_byte;
      end else begin
        res_valid        = 1'b1;
        res.kind         = KIND_PIXEL;
        res.pixel        = {high_byte_hold, in_byte};
        res.row          = expected_index;
        res.column       = off[COL_W:1];
        res.frame_end    = (expected_index == LAST_INDEX) && (pos == LAST_PIX_POS);
        res.resync_count = resync_total;
      end
    end

    // end of packet: if kept, advance frame index; at the last, wrap and clear resync
    if (pos >= PKT_LAST_POS) begin
      pos_next = '0;
      if (packet_accepted_next) begin
        if (expected_index_next >= LAST_INDEX) begin
          expected_index_next = '0;
          resync_total_next   = '0;
        end else begin
          expected_index_next = expected_index_next + ROW_W'(1);
        end
      end
      packet_accepted_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos             <= '0;
      expected_index  <= '0;
      packet_accepted <= 1'b0;
      high_byte_hold  <= '0;
      resync_total    <= '0;
    end else if (accept) begin
      pos             <= pos_next;
      expected_index  <= expected_index_next;
      packet_accepted <= packet_accepted_next;
      high_byte_hold  <= high_byte_hold_next;
      resync_total    <= resync_total_next;
    end
  end

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (accept && res_valid) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.frame_end;
  assign m_tdata  = {{(OUT_DATA_W-PIXEL_W-ROW_W-COL_W-COUNT_W){1'b0}},
                     out_res.resync_count, out_res.column, out_res.row, out_res.pixel};

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  a_pos_in_packet: assert property (@(posedge clk) disable iff (rst)
    pos <= PKT_LAST_POS)
    else $error("byte position beyond packet length");

  a_no_accept_at_start: assert property (@(posedge clk) disable iff (rst)
    (pos == '0) |-> !packet_accepted)
    else $error("packet marked accepted before its ID byte");

  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    expected_index <= LAST_INDEX)
    else $error("expected packet index beyond frame");
`endif

endmodule
